// ===== design/rsnp_pkg.sv =====
// Package for the ray/sphere nearest pick block: widths, register indexes,
// queue entry and helpers. No dependencies.
package rsnp_pkg;
   localparam int FRAC_BITS   = 16;
   localparam int ID_W        = 32;
   localparam int DIST_W      = 48;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_DATA_W  = 224;
   localparam int RSP_DATA_W  = 80;
   localparam int QDEPTH      = 2;
   localparam int SQ_VAL_W    = 64;
   localparam int SQ_STEPS    = (64 + FRAC_BITS + 1) / 2;

   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DIR_X    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DIR_Y    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DIR_Z    = 3'd5;

   // one classified entity between front and back
   typedef struct packed {
      logic              has_entity;
      logic              list_end;
      logic [ID_W-1:0]   entity_id;
      logic signed [32:0] m_x;
      logic signed [32:0] m_y;
      logic signed [32:0] m_z;
      logic signed [31:0] s_max;
   } entry_type;
endpackage

// ===== design/rsnp_front.sv =====
// Front end: accepts entity transactions, forms origin minus center and the
// largest scale, and pushes the result into the queue. Uses rsnp_pkg.
module rsnp_front import rsnp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   input  logic signed [31:0]    org_x,
   input  logic signed [31:0]    org_y,
   input  logic signed [31:0]    org_z,
   output logic                  q_valid,
   output entry_type             q_data,
   input  logic                  q_pop
);
   entry_type         mem_ff [QDEPTH];
   logic              wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]        cnt_ff, cnt_in;
   entry_type         ent;
   logic signed [31:0] sx, sy, sz, smax;
   logic              push;

   // form the entry
   always_comb begin
      sx = req_tdata[159:128];
      sy = req_tdata[191:160];
      sz = req_tdata[223:192];
      smax = sx;
      if (sy > smax) smax = sy;
      if (sz > smax) smax = sz;
      ent.has_entity = req_tuser;
      ent.list_end   = req_tlast;
      ent.entity_id  = req_tdata[31:0];
      ent.m_x = 33'(org_x) - 33'($signed(req_tdata[63:32]));
      ent.m_y = 33'(org_y) - 33'($signed(req_tdata[95:64]));
      ent.m_z = 33'(org_z) - 33'($signed(req_tdata[127:96]));
      ent.s_max = smax;
   end

   assign req_tready = (cnt_ff != 2'(QDEPTH));
   assign push   = req_tvalid && req_tready;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_data  = mem_ff[rp_ff];

   // advance queue pointers
   always_comb begin
      wp_in  = push  ? ~wp_ff : wp_ff;
      rp_in  = q_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= ent;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(QDEPTH)) else $error("queue overflow");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'(QDEPTH) |-> !req_tready) else $error("accept while full");
endmodule

// ===== design/rsnp_sqrt.sv =====
// Digit-by-digit square root: floor(sqrt(v * 2^FRAC_BITS)),
// one result bit per cycle. Uses rsnp_pkg.
module rsnp_sqrt import rsnp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SQ_VAL_W-1:0] value,
   output logic                done,
   output logic [47:0]         root
);
   localparam int EXT_W = SQ_STEPS * 2;
   logic [EXT_W-1:0] v_ff, v_in;
   logic [47:0]      root_ff, root_in;
   logic [49:0]      rem_ff, rem_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [49:0]      rem_sh, trial;

   // one root digit per cycle
   always_comb begin
      rem_sh = {rem_ff[47:0], v_ff[EXT_W-1 -: 2]};
      trial  = {root_ff, 2'b01};
      v_in = v_ff; root_in = root_ff; rem_in = rem_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         v_in = EXT_W'({value, FRAC_BITS'(0)});
         root_in = '0; rem_in = '0; cnt_in = 6'(SQ_STEPS); busy_in = 1'b1;
      end else if (busy_ff) begin
         v_in = {v_ff[EXT_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in = rem_sh - trial; root_in = {root_ff[46:0], 1'b1};
         end else begin
            rem_in = rem_sh; root_in = {root_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      v_ff <= v_in; root_ff <= root_in; rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

// ===== design/rsnp_back.sv =====
// Back end: sequenced sphere test, nearest-hit tracking and result register.
// Uses rsnp_pkg and rsnp_sqrt.
module rsnp_back import rsnp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  entry_type             q_data,
   output logic                  q_pop,
   input  logic signed [17:0]    dir_x,
   input  logic signed [17:0]    dir_y,
   input  logic signed [17:0]    dir_z,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);
   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001, S_MUL  = 7'b0000010, S_SUM  = 7'b0000100,
      S_BB   = 7'b0001000, S_DISC = 7'b0010000, S_SQRT = 7'b0100000,
      S_DONE = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   entry_type cur_ff;
   logic [1:0] ax_ff, ax_in;
   logic signed [70:0] dot_ff;
   logic [65:0]  mm_ff;
   logic [65:0]  r2_ff;
   logic signed [36:0] b_ff;
   logic [71-FRAC_BITS:0] bb_ff;
   logic         rej_ff;
   logic [DIST_W-1:0] best_d_ff;
   logic [ID_W-1:0]   best_id_ff;
   logic              any_ff;
   logic              out_v_ff;
   logic              out_u_ff;
   logic [RSP_DATA_W-1:0] out_d_ff;
   logic signed [32:0] m_sel;
   logic signed [17:0] d_sel;
   logic [31:0]  m_abs, s_abs;
   logic [63:0]  m_sq, s_sq;
   logic signed [50:0] md;
   logic [35:0]  b_abs;
   logic [35-FRAC_BITS:0] b_hi;
   logic [FRAC_BITS-1:0]  b_lo;
   logic [71-2*FRAC_BITS:0] hh;
   logic [35:0]  hl;
   logic [2*FRAC_BITS-1:0] ll;
   logic signed [67:0] disc;
   logic         sq_start, sq_done;
   logic [47:0]  sq_root;
   logic signed [56:0] t;
   logic [DIST_W-1:0] d_fin;
   logic         hit, finish;

   // per-axis operands, one axis per cycle through a single multiplier pair
   always_comb begin
      case (ax_ff)
         2'd0:    begin m_sel = cur_ff.m_x; d_sel = dir_x; end
         2'd1:    begin m_sel = cur_ff.m_y; d_sel = dir_y; end
         default: begin m_sel = cur_ff.m_z; d_sel = dir_z; end
      endcase
      m_abs = m_sel[32] ? 32'(-m_sel) : 32'(m_sel);
      m_sq  = m_abs * m_abs;
      md    = m_sel * d_sel;
      s_abs = cur_ff.s_max[31] ? 32'(-cur_ff.s_max) : 32'(cur_ff.s_max);
      s_sq  = s_abs * s_abs;
      // square of b split into high and low halves
      b_abs = b_ff[36] ? 36'(-b_ff) : 36'(b_ff);
      b_hi  = b_abs[35:FRAC_BITS];
      b_lo  = b_abs[FRAC_BITS-1:0];
      hh    = b_hi * b_hi;
      hl    = b_hi * b_lo;
      ll    = b_lo * b_lo;
      disc  = 68'($signed({1'b0, bb_ff})) - 68'($signed({1'b0, mm_ff}))
              + 68'($signed({1'b0, r2_ff}));
   end

   assign sq_start = (state_ff == S_DISC) && !rej_ff && !disc[67];
   rsnp_sqrt u_sqrt (.clock(clock), .reset(reset), .start(sq_start),
      .value(SQ_VAL_W'(disc)), .done(sq_done), .root(sq_root));

   always_comb begin
      t = -57'(b_ff) - 57'($signed({1'b0, sq_root}));
      if (t < 0) d_fin = '0;
      else if (t > 57'($signed({1'b0, {DIST_W{1'b1}}}))) d_fin = '1;
      else d_fin = DIST_W'(t);
      hit = (state_ff == S_SQRT) && sq_done;
   end

   assign finish = (state_ff == S_DONE);
   assign q_pop  = finish && !(cur_ff.list_end && out_v_ff && !rsp_tready);

   // sequencer
   always_comb begin
      state_in = state_ff; ax_in = ax_ff;
      case (state_ff)
         S_IDLE: if (q_valid) state_in = q_data.has_entity ? S_MUL : S_DONE;
         S_MUL: begin
            ax_in = ax_ff + 2'd1;
            if (ax_ff == 2'd2) state_in = S_SUM;
         end
         S_SUM:  state_in = S_BB;
         S_BB:   state_in = S_DISC;
         S_DISC: state_in = (rej_ff || disc[67]) ? S_DONE : S_SQRT;
         S_SQRT: if (sq_done) state_in = S_DONE;
         S_DONE: if (q_pop) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_IDLE) ax_in = 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; ax_ff <= 2'd0; out_v_ff <= 1'b0;
         best_d_ff <= '1; best_id_ff <= '0; any_ff <= 1'b0;
      end else begin
         state_ff <= state_in; ax_ff <= ax_in;
         // emit on list end and clear the run
         if (q_pop && cur_ff.list_end) begin
            out_v_ff <= 1'b1;
            best_d_ff <= '1; best_id_ff <= '0; any_ff <= 1'b0;
         end else begin
            if (rsp_tvalid && rsp_tready) out_v_ff <= 1'b0;
            if (hit && (!any_ff || d_fin < best_d_ff)) begin
               best_d_ff <= d_fin; best_id_ff <= cur_ff.entity_id; any_ff <= 1'b1;
            end
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && q_valid) begin
         cur_ff <= q_data; dot_ff <= '0; mm_ff <= '0; rej_ff <= 1'b0;
      end
      if (state_ff == S_MUL) begin
         dot_ff <= dot_ff + 71'(md);
         mm_ff  <= mm_ff + 66'(m_sq >> FRAC_BITS);
         if (ax_ff == 2'd0) r2_ff <= (66'(s_sq) + {1'b0, s_sq, 1'b0}) >> FRAC_BITS;
      end
      if (state_ff == S_SUM) b_ff <= 37'(dot_ff >>> FRAC_BITS);
      if (state_ff == S_BB) begin
         bb_ff  <= {hh, FRAC_BITS'(0)} + (72-FRAC_BITS)'({hl, 1'b0})
                   + (72-FRAC_BITS)'(ll >> FRAC_BITS);
         rej_ff <= (mm_ff > r2_ff) && (b_ff > 0);
      end
      if (q_pop && cur_ff.list_end) begin
         out_d_ff <= {any_ff ? best_d_ff : DIST_W'(0), any_ff ? best_id_ff : ID_W'(0)};
         out_u_ff <= any_ff;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;
   assign rsp_tuser  = out_u_ff;

   a_emit_last: assert property (@(posedge clock) disable iff (reset)
      (q_pop && cur_ff.list_end) |=> rsp_tvalid) else $error("lost result");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (q_pop && cur_ff.list_end) |=> !any_ff) else $error("run not cleared");
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      sq_done |-> state_ff == S_SQRT) else $error("stray root");
endmodule

// ===== design/ray_sphere_nearest_pick_top.sv =====
// Top level of the ray/sphere nearest pick block: configuration registers,
// front end with queue, back end. Uses rsnp_pkg, rsnp_front, rsnp_back.
//
//  channel  | ports                               | moves
//  req      | req_tvalid/tready/tdata/tuser/tlast | one entity (tlast = list_end)
//  rsp      | rsp_tvalid/tready/tdata/tuser       | found flag, id, distance
//  csr      | csr_we/csr_index/csr_wdata          | origin and direction writes
//
// A tested entity goes from the queue head through load, the axis multiplies, setup
// (sum, b squared, discriminant), the one-bit-per-cycle square root unit and retire.
// Rejected entities skip the root; items without an entity go from load to retire.
// Reset is synchronous; the queue holds two entries, so input stalls only
// when it is full, and the result register stalls the back end only on list end.
module ray_sphere_nearest_pick_top import rsnp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // entity_id, pos_x, pos_y, pos_z, scale_x, scale_y, scale_z
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // has_entity
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // hit_id, hit_distance
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // hit_found
   output logic                  rsp_tuser,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   logic signed [31:0] ox_ff, oy_ff, oz_ff;
   logic signed [17:0] dx_ff, dy_ff, dz_ff;
   logic      q_valid, q_pop;
   entry_type q_data;

   // hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ox_ff <= '0; oy_ff <= '0; oz_ff <= '0;
         dx_ff <= '0; dy_ff <= '0; dz_ff <= 18'sd65536;
      end else if (csr_we) begin
         case (csr_index)
            REG_ORIGIN_X: ox_ff <= csr_wdata;
            REG_ORIGIN_Y: oy_ff <= csr_wdata;
            REG_ORIGIN_Z: oz_ff <= csr_wdata;
            REG_DIR_X:    dx_ff <= csr_wdata[17:0];
            REG_DIR_Y:    dy_ff <= csr_wdata[17:0];
            REG_DIR_Z:    dz_ff <= csr_wdata[17:0];
            default: ;
         endcase
      end
   end

   rsnp_front u_front (.clock(clock), .reset(reset), .req_tvalid(req_tvalid),
      .req_tready(req_tready), .req_tdata(req_tdata), .req_tuser(req_tuser),
      .req_tlast(req_tlast), .org_x(ox_ff), .org_y(oy_ff), .org_z(oz_ff),
      .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop));

   rsnp_back u_back (.clock(clock), .reset(reset), .q_valid(q_valid),
      .q_data(q_data), .q_pop(q_pop), .dir_x(dx_ff), .dir_y(dy_ff),
      .dir_z(dz_ff), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser));
endmodule
